// File: rtl/mpwc_pkg.sv
// Shared types and constants for the multichannel pulse width capture block.
`timescale 1ns / 1ps
`default_nettype none

package mpwc_pkg;

    localparam int PIN_BITS       = 8;
    localparam int FIELD_BITS     = 16;
    localparam int OUT_WIDTHS     = 8;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [31:0]             WIDTH_RESET  = 32'h0000_0EA6;
    localparam logic [FIELD_BITS-1:0]   TOP_RESET    = 16'd49999;
    localparam logic [PIN_BITS-1:0]     ENABLE_RESET = 8'hFF;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMER_TOP      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_ENABLE = 4'd1;

    typedef struct packed {
        logic [PIN_BITS-1:0]   pin_levels;
        logic [FIELD_BITS-1:0] timestamp;
    } in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] width_ch0;
        logic [FIELD_BITS-1:0] width_ch1;
        logic [FIELD_BITS-1:0] width_ch2;
        logic [FIELD_BITS-1:0] width_ch3;
        logic [FIELD_BITS-1:0] width_ch4;
        logic [FIELD_BITS-1:0] width_ch5;
        logic [FIELD_BITS-1:0] width_ch6;
        logic [FIELD_BITS-1:0] width_ch7;
        logic [PIN_BITS-1:0]   completed_mask;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/mpwc_lane.sv
// One channel: edge detection, start time capture and width measurement.
`timescale 1ns / 1ps
`default_nettype none

module mpwc_lane #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic                  level,
    input  wire logic [TIMER_BITS-1:0] ts,
    input  wire logic [TIMER_BITS-1:0] top,
    output logic      [TIMER_BITS-1:0] width,
    output logic                       done
);
    import mpwc_pkg::*;

    logic                  level_reg;
    logic [TIMER_BITS-1:0] rise_reg;
    logic [TIMER_BITS-1:0] width_reg;
    logic                  rise;
    logic                  fall;
    logic [TIMER_BITS-1:0] span;

    always_comb begin
        rise = level & ~level_reg;
        fall = ~level & level_reg;
        // timer wrapped between the edges: add back the distance to the top
        if (ts >= rise_reg) begin
            span = ts - rise_reg;
        end else begin
            span = top - rise_reg + ts;
        end
        width = fall ? span : width_reg;
        done  = fall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            rise_reg  <= '0;
            width_reg <= TIMER_BITS'(WIDTH_RESET);
        end else if (step) begin
            level_reg <= level;
            if (rise) begin
                rise_reg <= ts;
            end
            width_reg <= width;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mpwc_merge.sv
// Gathers the lane widths and completion flags into the result register.
`timescale 1ns / 1ps
`default_nettype none

module mpwc_merge #(
    parameter int CHANNELS   = 8,
    parameter int TIMER_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 load,
    input  wire logic [CHANNELS-1:0][TIMER_BITS-1:0]  widths,
    input  wire logic [CHANNELS-1:0]                  dones,
    output logic                                      out_free,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output mpwc_pkg::out_t                            m_data
);
    import mpwc_pkg::*;

    logic [OUT_WIDTHS-1:0][FIELD_BITS-1:0] wv;
    logic [PIN_BITS-1:0]                   mask;
    out_t                                  result;
    out_t                                  m_data_reg;
    logic                                  m_valid_reg;
    logic                                  m_valid_next;

    // channels beyond the lane count read as zero
    for (genvar k = 0; k < OUT_WIDTHS; k++) begin : g_w
        if (k < CHANNELS) begin : g_on
            assign wv[k] = FIELD_BITS'(widths[k]);
        end else begin : g_off
            assign wv[k] = '0;
        end
    end

    for (genvar k = 0; k < PIN_BITS; k++) begin : g_m
        if (k < CHANNELS) begin : g_on
            assign mask[k] = dones[k];
        end else begin : g_off
            assign mask[k] = 1'b0;
        end
    end

    always_comb begin
        result.width_ch0      = wv[0];
        result.width_ch1      = wv[1];
        result.width_ch2      = wv[2];
        result.width_ch3      = wv[3];
        result.width_ch4      = wv[4];
        result.width_ch5      = wv[5];
        result.width_ch6      = wv[6];
        result.width_ch7      = wv[7];
        result.completed_mask = mask;
        out_free     = ~m_valid_reg | m_ready;
        m_valid_next = load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/multichannel_pulse_width_capture_top.sv
// Top level of the multichannel pulse width capture block.
//
// Each input transaction on s_* carries one sample of the channel pin levels
// and the period timer count. Every accepted sample yields exactly one result
// transaction on m_* with the latest width of every channel and a mask of the
// channels whose pulse ended with that sample.
// Configuration: cfg_index 0 writes timer_top, 1 writes channel_enable; other
// indexes are ignored. cfg_ready is always high; write only while idle.
// The result of an accepted sample is registered and shows on m_data in the next cycle.
// Throughput is one sample per cycle while m_ready is high; each channel has its
// own lane, so the rate is set by the single result register, freed as it is taken.
// While a result waits with m_ready low it is held and s_ready drops, so samples wait.
// Synchronous reset (aresetn low) clears the edge history and start times,
// sets every width to 3750 ticks, timer_top to 49999 and enables all channels.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_pulse_width_capture_top #(
    parameter int CHANNELS   = 8,
    parameter int TIMER_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire mpwc_pkg::in_t                          s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output mpwc_pkg::out_t                              m_data,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mpwc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [mpwc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import mpwc_pkg::*;

    logic [FIELD_BITS-1:0]                 timer_top_reg;
    logic [PIN_BITS-1:0]                   enable_reg;
    logic                                  step;
    logic                                  out_free;
    logic [CHANNELS-1:0]                   levels;
    logic [CHANNELS-1:0][TIMER_BITS-1:0]   widths;
    logic [CHANNELS-1:0]                   dones;
    logic [TIMER_BITS-1:0]                 ts;
    logic [TIMER_BITS-1:0]                 top;
    logic [PIN_BITS-1:0]                   levels8;

    assign cfg_ready = 1'b1;
    assign s_ready   = out_free;
    assign step      = s_valid & out_free;
    assign ts        = TIMER_BITS'(s_data.timestamp);
    assign top       = TIMER_BITS'(timer_top_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_top_reg <= TOP_RESET;
            enable_reg    <= ENABLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TIMER_TOP:      timer_top_reg <= cfg_data;
                REG_CHANNEL_ENABLE: enable_reg    <= cfg_data[PIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        // lanes without a pin stay low and never see an edge
        if (i < PIN_BITS) begin : g_pin
            assign levels[i] = s_data.pin_levels[i] & enable_reg[i];
        end else begin : g_nopin
            assign levels[i] = 1'b0;
        end

        mpwc_lane #(
            .TIMER_BITS (TIMER_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .level   (levels[i]),
            .ts      (ts),
            .top     (top),
            .width   (widths[i]),
            .done    (dones[i])
        );
    end

    mpwc_merge #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .widths   (widths),
        .dones    (dones),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign levels8 = s_data.pin_levels & enable_reg;

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted sample produced no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_done_only_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ((m_data.completed_mask & $past(levels8)) == '0))
        else $error("completion flagged on a channel still high");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
